FILE: sv/mhdc2p_pkg.sv
package mhdc2p_pkg;

  localparam int unsigned NUM_ITER = 51;
  localparam int unsigned VS_ITER  = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR = 2'd1;

  localparam logic [18:0] GAMMA_RST = 19'd109227;
  localparam logic [30:0] FLOOR_RST = 31'd1;
  localparam logic signed [19:0] Q_ONE = 20'sd65536;
  localparam logic [50:0] KE_CLAMP = 51'h4_0000_0000_0000;
  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] density;
    logic signed [31:0] momentum_x;
    logic signed [31:0] momentum_y;
    logic signed [31:0] momentum_z;
    logic signed [31:0] total_energy;
    logic signed [31:0] field_x;
    logic signed [31:0] field_y;
    logic signed [31:0] field_z;
  } mhd_in_t;

  typedef struct packed {
    logic signed [31:0] gas_pressure;
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic signed [31:0] velocity_z;
    logic [31:0]        field_magnitude;
    logic               below_floor;
  } mhd_out_t;

  // state of one digit step: three velocity dividers, kinetic divider, root
  typedef struct packed {
    logic               below;
    logic [2:0]         neg;
    logic signed [31:0] e;
    logic [46:0]        magn;
    logic [31:0]        div;
    logic [2:0][31:0]   vr;
    logic [2:0][31:0]   va;
    logic [2:0][31:0]   vq;
    logic [2:0]         vovf;
    logic [32:0]        kd;
    logic [32:0]        kr;
    logic [50:0]        kn;
    logic [50:0]        kq;
    logic               kovf;
    logic [63:0]        sn;
    logic [33:0]        sr;
    logic [31:0]        sres;
  } it_t;

  function automatic logic [31:0] mag32(logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic it_t it_step(it_t a, logic do_vs);
    it_t         r;
    logic [33:0] kt;
    logic [32:0] vt;
    logic [35:0] st;
    logic [35:0] stt;
    r = a;
    kt = {a.kr, a.kn[50]};
    if (kt >= {1'b0, a.kd}) begin
      r.kr = 33'(kt - {1'b0, a.kd});
      r.kq = {a.kq[49:0], 1'b1};
    end else begin
      r.kr = kt[32:0];
      r.kq = {a.kq[49:0], 1'b0};
    end
    r.kn = {a.kn[49:0], 1'b0};
    if (do_vs) begin
      for (int i = 0; i < 3; i++) begin
        vt = {a.vr[i], a.va[i][31]};
        if (vt >= {1'b0, a.div}) begin
          r.vr[i] = 32'(vt - {1'b0, a.div});
          r.vq[i] = {a.vq[i][30:0], 1'b1};
        end else begin
          r.vr[i] = vt[31:0];
          r.vq[i] = {a.vq[i][30:0], 1'b0};
        end
        r.va[i] = {a.va[i][30:0], 1'b0};
      end
      st  = {a.sr, a.sn[63:62]};
      stt = {2'b00, a.sres, 2'b01};
      if (st >= stt) begin
        r.sr   = 34'(st - stt);
        r.sres = {a.sres[30:0], 1'b1};
      end else begin
        r.sr   = st[33:0];
        r.sres = {a.sres[30:0], 1'b0};
      end
      r.sn = {a.sn[61:0], 2'b00};
    end
    return r;
  endfunction

  function automatic logic signed [31:0] vel_sat(logic [31:0] q, logic ovf, logic neg);
    if (!neg) begin
      return (ovf || q[31]) ? S32_MAX : $signed(q);
    end
    return (ovf || q > 32'h8000_0000) ? S32_MIN : $signed(32'(-q));
  endfunction

endpackage

FILE: sv/mhd_conservative_to_primitive.sv
// Channel  Dir  Handshake                 Payload
// in       in   in_valid_i / in_stall_o   in_data_i (mhd_in_t)
// out      out  out_valid_o / out_stall_i out_data_o (mhd_out_t)
// cfg      in   cfg_we_i                  cfg_idx_i, cfg_data_i
// One transfer per cycle in while not held; data passes input, square, sum
// registers, 51 one-bit kinetic-energy divider steps, then energy, product and
// output registers. Root and velocity dividers use only the first VS_ITER.
// The whole pipeline holds while a result waits and out_stall_i is high.
// Reset clears the valid bits and loads the default gamma and floor.
module mhd_conservative_to_primitive
  import mhdc2p_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  mhd_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output mhd_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef struct packed {
    logic               below;
    logic [2:0]         neg;
    logic [31:0]        rho;
    logic [2:0][31:0]   ma;
    logic signed [31:0] e;
    logic [2:0][63:0]   bsq;
    logic [2:0][63:0]   msqp;
  } p1_t;

  typedef struct packed {
    logic               below;
    logic [2:0]         neg;
    logic [31:0]        rho;
    logic [2:0][31:0]   ma;
    logic signed [31:0] e;
    logic [63:0]        b2;
    logic [63:0]        msq;
  } p2_t;

  typedef struct packed {
    logic                   below;
    logic [2:0][31:0]       vel;
    logic [31:0]            bmag;
    logic signed [52:0]     diff;
  } q1_t;

  typedef struct packed {
    logic                   below;
    logic [2:0][31:0]       vel;
    logic [31:0]            bmag;
    logic                   negp;
    logic [70:0]            prod;
  } q2_t;

  logic [18:0] gamma_q;
  logic [30:0] floor_q;
  logic        adv;

  logic    p0_vld_q, p1_vld_q, p2_vld_q, q1_vld_q, q2_vld_q, out_vld_q;
  mhd_in_t p0_q;
  p1_t     p1_d, p1_q;
  p2_t     p2_d, p2_q;
  it_t     it_init;
  it_t     it_d [NUM_ITER];
  it_t     it_q [NUM_ITER];
  logic [NUM_ITER-1:0] it_vld_q;
  q1_t      q1_d, q1_q;
  q2_t      q2_d, q2_q;
  mhd_out_t out_d, out_q;

  assign adv         = !out_vld_q || !out_stall_i;
  assign in_stall_o  = !adv;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q <= GAMMA_RST;
      floor_q <= FLOOR_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_GAMMA) begin
        gamma_q <= cfg_data_i[18:0];
      end else if (cfg_idx_i == CFG_FLOOR) begin
        floor_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_vld_q  <= 1'b0;
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      it_vld_q  <= '0;
      q1_vld_q  <= 1'b0;
      q2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      p0_vld_q  <= in_valid_i;
      p1_vld_q  <= p0_vld_q;
      p2_vld_q  <= p1_vld_q;
      it_vld_q  <= {it_vld_q[NUM_ITER-2:0], p2_vld_q};
      q1_vld_q  <= it_vld_q[NUM_ITER-1];
      q2_vld_q  <= q1_vld_q;
      out_vld_q <= q2_vld_q;
    end
  end

  always_comb begin
    logic [2:0][31:0] mb;
    mb[0] = mag32(p0_q.field_x);
    mb[1] = mag32(p0_q.field_y);
    mb[2] = mag32(p0_q.field_z);
    p1_d.ma[0] = mag32(p0_q.momentum_x);
    p1_d.ma[1] = mag32(p0_q.momentum_y);
    p1_d.ma[2] = mag32(p0_q.momentum_z);
    p1_d.neg   = {p0_q.momentum_z[31], p0_q.momentum_y[31], p0_q.momentum_x[31]};
    p1_d.rho   = p0_q.density;
    p1_d.e     = p0_q.total_energy;
    p1_d.below = p0_q.density <= $signed({1'b0, floor_q});
    for (int i = 0; i < 3; i++) begin
      p1_d.bsq[i]  = mb[i] * mb[i];
      p1_d.msqp[i] = p1_d.ma[i] * p1_d.ma[i];
    end
  end

  always_comb begin
    p2_d.below = p1_q.below;
    p2_d.neg   = p1_q.neg;
    p2_d.rho   = p1_q.rho;
    p2_d.ma    = p1_q.ma;
    p2_d.e     = p1_q.e;
    p2_d.b2    = p1_q.bsq[0] + p1_q.bsq[1] + p1_q.bsq[2];
    p2_d.msq   = p1_q.msqp[0] + p1_q.msqp[1] + p1_q.msqp[2];
  end

  always_comb begin
    it_init       = '0;
    it_init.below = p2_q.below;
    it_init.neg   = p2_q.neg;
    it_init.e     = p2_q.e;
    it_init.magn  = p2_q.b2[63:17];
    it_init.div   = p2_q.rho;
    for (int i = 0; i < 3; i++) begin
      it_init.vr[i]   = {16'b0, p2_q.ma[i][31:16]};
      it_init.va[i]   = {p2_q.ma[i][15:0], 16'b0};
      it_init.vovf[i] = {16'b0, p2_q.ma[i][31:16]} >= p2_q.rho;
    end
    it_init.kd   = {p2_q.rho, 1'b0};
    it_init.kr   = {20'b0, p2_q.msq[63:51]};
    it_init.kovf = {20'b0, p2_q.msq[63:51]} >= it_init.kd;
    it_init.kn   = p2_q.msq[50:0];
    it_init.sn   = p2_q.b2;
  end

  for (genvar k = 0; k < NUM_ITER; k++) begin : g_iter
    if (k == 0) begin : g_first
      assign it_d[k] = it_step(it_init, 1'b1);
    end else begin : g_next
      assign it_d[k] = it_step(it_q[k-1], 1'(k < VS_ITER));
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        it_q[k] <= it_d[k];
      end
    end
  end

  always_comb begin
    it_t         t;
    logic [50:0] ke;
    t  = it_q[NUM_ITER-1];
    ke = (t.kovf || t.kq > KE_CLAMP) ? KE_CLAMP : t.kq;
    q1_d.below = t.below;
    q1_d.bmag  = t.sres;
    for (int i = 0; i < 3; i++) begin
      q1_d.vel[i] = vel_sat(t.vq[i], t.vovf[i], t.neg[i]);
    end
    q1_d.diff = $signed({{21{t.e[31]}}, t.e}) - $signed({2'b0, ke})
                - $signed({6'b0, t.magn});
  end

  always_comb begin
    logic signed [19:0] g1;
    logic [18:0]        ag;
    logic [51:0]        ad;
    g1 = $signed({1'b0, gamma_q}) - Q_ONE;
    ag = g1[19] ? 19'(-g1) : g1[18:0];
    ad = q1_q.diff[52] ? 52'(-q1_q.diff) : q1_q.diff[51:0];
    q2_d.below = q1_q.below;
    q2_d.vel   = q1_q.vel;
    q2_d.bmag  = q1_q.bmag;
    q2_d.negp  = q1_q.diff[52] != g1[19];
    q2_d.prod  = ad * ag;
  end

  always_comb begin
    logic [48:0]        up;
    logic signed [31:0] p;
    up = {1'b0, q2_q.prod[47:0]} + 49'h0_ffff;
    if (q2_q.prod > 71'h0_ffff_ffff_ffff) begin
      p = q2_q.negp ? S32_MIN : S32_MAX;
    end else if (q2_q.negp) begin
      p = (up[48:16] > 33'h0_8000_0000) ? S32_MIN : $signed(32'(-up[48:16]));
    end else begin
      p = q2_q.prod[47] ? S32_MAX : $signed(q2_q.prod[47:16]);
    end
    out_d.field_magnitude = q2_q.bmag;
    out_d.below_floor     = q2_q.below;
    if (q2_q.below) begin
      out_d.gas_pressure = '0;
      out_d.velocity_x   = '0;
      out_d.velocity_y   = '0;
      out_d.velocity_z   = '0;
    end else begin
      out_d.gas_pressure = p;
      out_d.velocity_x   = q2_q.vel[0];
      out_d.velocity_y   = q2_q.vel[1];
      out_d.velocity_z   = q2_q.vel[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p0_q  <= in_data_i;
      p1_q  <= p1_d;
      p2_q  <= p2_d;
      q1_q  <= q1_d;
      q2_q  <= q2_d;
      out_q <= out_d;
    end
  end

`ifndef ASSERT_OFF
  a_below_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.below_floor |-> out_q.gas_pressure == 0 &&
    out_q.velocity_x == 0 && out_q.velocity_y == 0 && out_q.velocity_z == 0)
    else $error("below-floor result not zeroed");

  a_hold_valids: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(it_vld_q) && $stable(q1_vld_q) && $stable(p0_vld_q))
    else $error("pipeline moved while held");

  a_ke_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q1_vld_q && !q1_q.below |-> q1_q.diff <= $signed(53'h7fff_ffff))
    else $error("energy difference above total energy bound");
`endif

endmodule
